@@ rtl/vsmt_pkg.sv @@
// vsmt_pkg: shared types and codes for the variable slot match table
// holds the record kind codes, the status codes and the table entry layout
// no dependencies
package vsmt_pkg;

	localparam int KindW   = 2;
	localparam int OffsetW = 32;
	localparam int RepeatW = 16;
	localparam int TotalW  = 9;
	localparam int StatusW = 2;

	typedef enum logic [KindW-1:0] {
		KIND_EMPTY = 2'd0,
		KIND_ARG   = 2'd1,
		KIND_LOCAL = 2'd2,
		KIND_BAD   = 2'd3
	} kind_t;

	typedef enum logic [StatusW-1:0] {
		ST_MATCH  = 2'd0,
		ST_INSERT = 2'd1,
		ST_FULL   = 2'd2,
		ST_CLEAR  = 2'd3
	} status_t;

	localparam logic MODE_CLEAR = 1'b0;
	localparam logic MODE_ADD   = 1'b1;

	localparam logic [RepeatW-1:0] REPEAT_MAX = {RepeatW{1'b1}};
	localparam logic [TotalW-1:0]  TOTAL_MAX  = {TotalW{1'b1}};

	typedef struct packed {
		logic [KindW-1:0]          kind;
		logic signed [OffsetW-1:0] offset;
		logic [RepeatW-1:0]        repeats;
	} entry_t;

endpackage

@@ rtl/variable_slot_match_table_core.sv @@
// variable_slot_match_table_core: stack-variable record table with serial match scan
// depends on vsmt_pkg (codes, entry layout); holds the table memory and its sequencer
//
//   channel | beat fields                                   | direction
//   --------+-----------------------------------------------+----------
//   s_axis  | tuser: mode, kind   tdata: offset              | in
//   m_axis  | tuser: status  tdata: repeat_count, arg_total, | out
//           |        local_total (padded to 40 bits)         |
//
// an add beat reads the occupied slots of the table memory serially from slot 0, one slot
// per cycle, and stops at the first hit; a miss reads all N occupied slots (at most
// TABLE_DEPTH), none on an empty table, before it inserts or reports full
// a clear beat or a beat with a bad kind skips the scan
// slots fill from the bottom and are only emptied all at once, so a fill count
// marks which slots are live: reset and clear just zero it, no sweep needed
// the input is taken while the previous result still waits in the output register;
// a stalled output holds the finished result and the sequencer until it is taken
module variable_slot_match_table_core #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // [0] mode, [2:1] kind
	input  logic [31:0] s_tdata,   // [31:0] offset
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic [39:0] m_tdata    // [15:0] repeat_count, [24:16] arg_total,
	                               // [33:25] local_total, [39:34] zero
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t state_q;

	// latched beat
	logic [vsmt_pkg::KindW-1:0]          kind_q;
	logic signed [vsmt_pkg::OffsetW-1:0] offset_q;

	// table bookkeeping
	logic [CW-1:0]                fill_q;     // slots 0..fill_q-1 are live
	logic [CW-1:0]                issue_q;    // next slot to read
	logic                         vld_s1;     // read data is returning this cycle
	logic [AW-1:0]                addr_s1;    // slot of the returning data
	logic [vsmt_pkg::TotalW-1:0]  arg_tot_q;
	logic [vsmt_pkg::TotalW-1:0]  loc_tot_q;

	// finished result waiting for the output register
	logic [vsmt_pkg::StatusW-1:0] res_status_q;
	logic [vsmt_pkg::RepeatW-1:0] res_repeat_q;

	// output register
	logic [vsmt_pkg::StatusW-1:0] out_status_q;
	logic [vsmt_pkg::RepeatW-1:0] out_repeat_q;
	logic [vsmt_pkg::TotalW-1:0]  out_arg_q;
	logic [vsmt_pkg::TotalW-1:0]  out_loc_q;
	logic                         out_vld_q;

	// table memory, one read and one write port, registered read
	vsmt_pkg::entry_t mem [TABLE_DEPTH];
	vsmt_pkg::entry_t rd_data;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	vsmt_pkg::entry_t mem_wd;
	logic             mem_re;

	logic                         in_beat;
	logic                         hit;
	logic                         scan_end;
	logic [vsmt_pkg::RepeatW-1:0] bumped;

	assign s_tready = (state_q == S_IDLE);
	assign in_beat  = s_tvalid && s_tready;

	// compare the returning slot against the latched record
	assign hit = vld_s1 && (rd_data.kind == kind_q) && (rd_data.offset == offset_q);
	assign bumped = (rd_data.repeats == vsmt_pkg::REPEAT_MAX) ? vsmt_pkg::REPEAT_MAX
		: rd_data.repeats + vsmt_pkg::RepeatW'(1);
	// all live slots read and compared without a hit
	assign scan_end = !vld_s1 && (issue_q == fill_q);

	assign mem_re = (state_q == S_SCAN) && !hit && (issue_q != fill_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s1;
		mem_wd = '{kind: kind_q, offset: offset_q, repeats: bumped};
		if (state_q == S_SCAN) begin
			if (hit) begin
				mem_we = 1'b1;
			end else if (scan_end && (fill_q != DEPTH_C)) begin
				// insert into the lowest empty slot, which is the fill point
				mem_we = 1'b1;
				mem_wa = fill_q[AW-1:0];
				mem_wd = '{kind: kind_q, offset: offset_q, repeats: '0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data <= mem[issue_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= '0;
			offset_q     <= '0;
			fill_q       <= '0;
			issue_q      <= '0;
			vld_s1       <= 1'b0;
			addr_s1      <= '0;
			arg_tot_q    <= '0;
			loc_tot_q    <= '0;
			res_status_q <= '0;
			res_repeat_q <= '0;
			out_status_q <= '0;
			out_repeat_q <= '0;
			out_arg_q    <= '0;
			out_loc_q    <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			vld_s1  <= mem_re;
			addr_s1 <= issue_q[AW-1:0];
			if (mem_re) begin
				issue_q <= issue_q + CW'(1);
			end

			// output register drains on its own unless a new result is loaded this cycle
			if (out_vld_q && m_tready && (state_q != S_DONE)) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						kind_q       <= s_tuser[2:1];
						offset_q     <= s_tdata;
						issue_q      <= '0;
						res_repeat_q <= '0;
						if (s_tuser[0] == vsmt_pkg::MODE_CLEAR) begin
							fill_q       <= '0;
							arg_tot_q    <= '0;
							loc_tot_q    <= '0;
							res_status_q <= vsmt_pkg::ST_CLEAR;
							state_q      <= S_DONE;
						end else if (s_tuser[2:1] != vsmt_pkg::KIND_ARG &&
							s_tuser[2:1] != vsmt_pkg::KIND_LOCAL) begin
							// bad kind: rejected, nothing changes
							res_status_q <= vsmt_pkg::ST_FULL;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_status_q <= vsmt_pkg::ST_MATCH;
						res_repeat_q <= bumped;
						state_q      <= S_DONE;
					end else if (scan_end) begin
						if (fill_q == DEPTH_C) begin
							res_status_q <= vsmt_pkg::ST_FULL;
						end else begin
							res_status_q <= vsmt_pkg::ST_INSERT;
							fill_q       <= fill_q + CW'(1);
							if (kind_q == vsmt_pkg::KIND_ARG) begin
								if (arg_tot_q != vsmt_pkg::TOTAL_MAX) begin
									arg_tot_q <= arg_tot_q + vsmt_pkg::TotalW'(1);
								end
							end else if (loc_tot_q != vsmt_pkg::TOTAL_MAX) begin
								loc_tot_q <= loc_tot_q + vsmt_pkg::TotalW'(1);
							end
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hand the result over once the output register is free
					if (!out_vld_q || m_tready) begin
						out_vld_q    <= 1'b1;
						out_status_q <= res_status_q;
						out_repeat_q <= res_repeat_q;
						out_arg_q    <= arg_tot_q;
						out_loc_q    <= loc_tot_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'd0, out_loc_q, out_arg_q, out_repeat_q};

endmodule
